// ===== rtl/twms_pkg.sv =====
// shared types and constants of the tile wrap/mirror sampler
// field widths, config register codes and the pipeline records
// no dependencies
package twms_pkg;

  // field widths
  localparam int POS_W      = 15;  // pixel position, signed
  localparam int WIN_W      = 15;  // window size, unsigned
  localparam int OFF_W      = 16;  // sample offset, signed
  localparam int TILE_W     = 14;  // tile size, period and remainder
  localparam int SAMPLE_W   = 13;  // sample coordinate
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // largest tile size honored, bigger sizes are clamped
  localparam int MAX_TILE = 8192;
  localparam logic [TILE_W-1:0] TILE_MAX = TILE_W'(MAX_TILE);

  // position plus offset, and its magnitude
  localparam int VAL_W = OFF_W + 1;
  localparam int MAG_W = OFF_W;

  // remainder pipeline: bits retired per stage and stage count
  localparam int STEPS      = 4;
  localparam int DIV_STAGES = MAG_W / STEPS;

  // config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_WIDTH  = 3'd0,
    REG_WINDOW_HEIGHT = 3'd1,
    REG_OFFSET_X      = 3'd2,
    REG_OFFSET_Y      = 3'd3,
    REG_TILE_WIDTH    = 3'd4,
    REG_TILE_HEIGHT   = 3'd5,
    REG_MIRROR_EDGES  = 3'd6
  } cfg_reg_t;

  // config register file contents
  typedef struct packed {
    logic [WIN_W-1:0]         window_width;
    logic [WIN_W-1:0]         window_height;
    logic signed [OFF_W-1:0]  offset_x;
    logic signed [OFF_W-1:0]  offset_y;
    logic [TILE_W-1:0]        tile_width;
    logic [TILE_W-1:0]        tile_height;
    logic                     mirror_edges;
  } cfg_t;

  // one axis in flight through the remainder pipeline
  typedef struct packed {
    logic [MAG_W-1:0]  mag;   // dividend bits not yet retired, msb first
    logic [TILE_W-1:0] rem;   // partial remainder, always below per
    logic [TILE_W-1:0] per;   // period
    logic [TILE_W-1:0] size;  // clamped tile size
    logic              neg;   // position plus offset was negative
    logic              zero;  // tile size of 0 or 1
  } lane_t;

  // one request in flight
  typedef struct packed {
    logic  transparent;
    logic  mirror;
    lane_t x;
    lane_t y;
  } item_t;

  // one result
  typedef struct packed {
    logic                transparent;
    logic [SAMPLE_W-1:0] sample_x;
    logic [SAMPLE_W-1:0] sample_y;
  } sample_t;

endpackage

// ===== rtl/twms_pixel_if.sv =====
// input channel of the tile wrap/mirror sampler: one pixel position per request
// depends on twms_pkg
interface twms_pixel_if;
  logic                              valid;
  logic                              ready;
  logic signed [twms_pkg::POS_W-1:0] pixel_x;
  logic signed [twms_pkg::POS_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== rtl/twms_sample_if.sv =====
// output channel of the tile wrap/mirror sampler: one sample coordinate per request
// depends on twms_pkg
interface twms_sample_if;
  logic                          valid;
  logic                          ready;
  logic                          transparent;
  logic [twms_pkg::SAMPLE_W-1:0] sample_x;
  logic [twms_pkg::SAMPLE_W-1:0] sample_y;

  modport source (output valid, output transparent, output sample_x, output sample_y,
                  input ready);
  modport sink (input valid, input transparent, input sample_x, input sample_y,
                output ready);
endinterface

// ===== rtl/twms_prep.sv =====
// first pipeline stage: window test, offset add, magnitude and period setup
// depends on twms_pkg
module twms_prep (
  input  logic                              clk,
  input  logic                              rst,
  input  twms_pkg::cfg_t                    cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [twms_pkg::POS_W-1:0] pixel_x,
  input  logic signed [twms_pkg::POS_W-1:0] pixel_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output twms_pkg::item_t                   out_item
);

  // set up one axis: signed sum, its magnitude and sign, clamped size, period
  function automatic twms_pkg::lane_t make_lane(
    input logic signed [twms_pkg::POS_W-1:0]  pos,
    input logic signed [twms_pkg::OFF_W-1:0]  off,
    input logic [twms_pkg::TILE_W-1:0]        size_raw,
    input logic                               mir
  );
    twms_pkg::lane_t                  l;
    logic signed [twms_pkg::VAL_W-1:0] sum;
    logic [twms_pkg::VAL_W-1:0]        neg_sum;
    logic [twms_pkg::TILE_W-1:0]       size_c;
    logic [twms_pkg::TILE_W:0]         dbl;
    sum     = twms_pkg::VAL_W'(pos) + twms_pkg::VAL_W'(off);
    neg_sum = twms_pkg::VAL_W'(0) - $unsigned(sum);
    l.neg   = sum[twms_pkg::VAL_W-1];
    l.mag   = l.neg ? neg_sum[twms_pkg::MAG_W-1:0] : sum[twms_pkg::MAG_W-1:0];
    size_c  = (size_raw > twms_pkg::TILE_MAX) ? twms_pkg::TILE_MAX : size_raw;
    l.zero  = (size_c <= twms_pkg::TILE_W'(1));
    dbl     = {size_c, 1'b0} - (twms_pkg::TILE_W + 1)'(2);
    if (l.zero) begin
      l.per = twms_pkg::TILE_W'(1);
    end else if (mir) begin
      l.per = dbl[twms_pkg::TILE_W-1:0];
    end else begin
      l.per = size_c;
    end
    l.size = size_c;
    l.rem  = '0;
    return l;
  endfunction

  twms_pkg::item_t nxt;
  logic            out_x;
  logic            out_y;

  // window test and lane setup
  always_comb begin
    out_x = pixel_x[twms_pkg::POS_W-1] ||
            ({1'b0, pixel_x[twms_pkg::POS_W-2:0]} >= cfg.window_width);
    out_y = pixel_y[twms_pkg::POS_W-1] ||
            ({1'b0, pixel_y[twms_pkg::POS_W-2:0]} >= cfg.window_height);
    nxt.transparent = out_x || out_y;
    nxt.mirror      = cfg.mirror_edges;
    nxt.x = make_lane(pixel_x, cfg.offset_x, cfg.tile_width, cfg.mirror_edges);
    nxt.y = make_lane(pixel_y, cfg.offset_y, cfg.tile_height, cfg.mirror_edges);
  end

  assign in_ready = !out_valid || out_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= nxt;
    end
  end

endmodule

// ===== rtl/twms_rem_stage.sv =====
// one remainder stage: retires STEPS dividend bits of both axes by restoring steps
// depends on twms_pkg
module twms_rem_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  twms_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output twms_pkg::item_t out_item
);

  // shift one dividend bit into the remainder and subtract the period if it fits
  function automatic twms_pkg::lane_t step_lane(input twms_pkg::lane_t l);
    twms_pkg::lane_t           r;
    logic [twms_pkg::TILE_W:0] t;
    r = l;
    t = {l.rem, l.mag[twms_pkg::MAG_W-1]};
    if (t >= {1'b0, l.per}) begin
      t = t - {1'b0, l.per};
    end
    r.rem = t[twms_pkg::TILE_W-1:0];
    r.mag = {l.mag[twms_pkg::MAG_W-2:0], 1'b0};
    return r;
  endfunction

  twms_pkg::item_t nxt;

  // STEPS dependent steps per axis
  always_comb begin
    nxt = in_item;
    for (int k = 0; k < twms_pkg::STEPS; k++) begin
      nxt.x = step_lane(nxt.x);
      nxt.y = step_lane(nxt.y);
    end
  end

  assign in_ready = !out_valid || out_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= nxt;
    end
  end

  // partial remainder stays below the period
  a_rem_x: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.x.rem < out_item.x.per))
    else $error("x partial remainder not below period");

  a_rem_y: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.y.rem < out_item.y.per))
    else $error("y partial remainder not below period");

endmodule

// ===== rtl/twms_fold.sv =====
// last stage: sign correction, mirror fold, transparency, output register
// depends on twms_pkg
module twms_fold (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  twms_pkg::item_t   in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output twms_pkg::sample_t out_sample
);

  // turn the magnitude remainder into the wrapped or mirrored coordinate
  function automatic logic [twms_pkg::TILE_W-1:0] fold_lane(
    input twms_pkg::lane_t l,
    input logic            mir
  );
    logic [twms_pkg::TILE_W-1:0] r;
    r = l.rem;
    if (l.neg && (r != '0)) begin
      r = l.per - r;
    end
    if (mir && (r >= l.size)) begin
      r = l.per - r;
    end
    if (l.zero) begin
      r = '0;
    end
    return r;
  endfunction

  logic [twms_pkg::TILE_W-1:0] fx;
  logic [twms_pkg::TILE_W-1:0] fy;
  twms_pkg::sample_t           nxt;

  // final coordinates, zero when transparent
  always_comb begin
    fx = fold_lane(in_item.x, in_item.mirror);
    fy = fold_lane(in_item.y, in_item.mirror);
    nxt.transparent = in_item.transparent;
    nxt.sample_x    = in_item.transparent ? '0 : fx[twms_pkg::SAMPLE_W-1:0];
    nxt.sample_y    = in_item.transparent ? '0 : fy[twms_pkg::SAMPLE_W-1:0];
  end

  assign in_ready = !out_valid || out_ready;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_sample <= nxt;
    end
  end

  // folded coordinate lands inside the tile
  a_fold_x: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_item.x.zero) |-> (fx < in_item.x.size))
    else $error("x sample outside tile");

  a_fold_y: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_item.y.zero) |-> (fy < in_item.y.size))
    else $error("y sample outside tile");

endmodule

// ===== rtl/tile_wrap_mirror_sampler_unit.sv =====
// top level of the tile wrap/mirror sampler: config registers and pipeline
// depends on twms_pkg, twms_pixel_if, twms_sample_if, twms_prep, twms_rem_stage,
// twms_fold
//
// Maps an output pixel position to a sample coordinate inside a source tile. A pixel
// outside the window comes back transparent with zero coordinates; otherwise the
// per-axis offset is added and the sum wraps (repeat) or folds back (mirror, period
// 2*size-2) into the tile, with tile sizes of 0 or 1 giving 0 and sizes above 8192
// treated as 8192. While the output is not stalled the unit takes one request per
// clock; it returns one result per request in order, through one setup stage, four
// remainder stages and one fold stage. The depth is set by the modulo of the 17-bit
// signed sum, a restoring remainder on its 16-bit magnitude retiring four dividend
// bits per stage. Write config registers only while no request is in flight.
module tile_wrap_mirror_sampler_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [twms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [twms_pkg::CFG_DATA_W-1:0] cfg_data,
  twms_pixel_if.sink                      pixel,
  twms_sample_if.source                   sample
);

  twms_pkg::cfg_t    cfg;
  twms_pkg::item_t   stage_item [twms_pkg::DIV_STAGES+1];
  logic              stage_valid [twms_pkg::DIV_STAGES+1];
  logic              stage_ready [twms_pkg::DIV_STAGES+1];
  twms_pkg::sample_t result;

  // config register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_width  <= '0;
      cfg.window_height <= '0;
      cfg.offset_x      <= '0;
      cfg.offset_y      <= '0;
      cfg.tile_width    <= twms_pkg::TILE_W'(1);
      cfg.tile_height   <= twms_pkg::TILE_W'(1);
      cfg.mirror_edges  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        twms_pkg::REG_WINDOW_WIDTH:  cfg.window_width  <= cfg_data[twms_pkg::WIN_W-1:0];
        twms_pkg::REG_WINDOW_HEIGHT: cfg.window_height <= cfg_data[twms_pkg::WIN_W-1:0];
        twms_pkg::REG_OFFSET_X:      cfg.offset_x      <= $signed(cfg_data);
        twms_pkg::REG_OFFSET_Y:      cfg.offset_y      <= $signed(cfg_data);
        twms_pkg::REG_TILE_WIDTH:    cfg.tile_width    <= cfg_data[twms_pkg::TILE_W-1:0];
        twms_pkg::REG_TILE_HEIGHT:   cfg.tile_height   <= cfg_data[twms_pkg::TILE_W-1:0];
        twms_pkg::REG_MIRROR_EDGES:  cfg.mirror_edges  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // setup stage
  twms_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .pixel_x   (pixel.pixel_x),
    .pixel_y   (pixel.pixel_y),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_item  (stage_item[0])
  );

  // remainder stages
  for (genvar s = 0; s < twms_pkg::DIV_STAGES; s++) begin : g_rem
    twms_rem_stage u_rem (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[s]),
      .in_ready  (stage_ready[s]),
      .in_item   (stage_item[s]),
      .out_valid (stage_valid[s+1]),
      .out_ready (stage_ready[s+1]),
      .out_item  (stage_item[s+1])
    );
  end

  // fold stage and output register
  twms_fold u_fold (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (stage_valid[twms_pkg::DIV_STAGES]),
    .in_ready   (stage_ready[twms_pkg::DIV_STAGES]),
    .in_item    (stage_item[twms_pkg::DIV_STAGES]),
    .out_valid  (sample.valid),
    .out_ready  (sample.ready),
    .out_sample (result)
  );

  assign sample.transparent = result.transparent;
  assign sample.sample_x    = result.sample_x;
  assign sample.sample_y    = result.sample_y;

  // transparent results carry zero coordinates
  a_transparent_zero: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.transparent) |->
      ((sample.sample_x == '0) && (sample.sample_y == '0)))
    else $error("transparent result with nonzero coordinates");

endmodule
